FILE: sv/qfau_pkg.sv
// ----------------------------------------------------------------------------
// qfau_pkg: shared types and constants of the quad float arithmetic unit
// Operation codes, quad word types, exponent constants and pipeline depth.
// ----------------------------------------------------------------------------
package qfau_pkg;

  typedef logic [127:0] quad_t;
  typedef logic [112:0] mant_t;
  typedef logic [14:0]  qexp_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_MUL    = 3'd2,
    OP_NEG    = 3'd3,
    OP_GT     = 3'd4,
    OP_EQ     = 3'd5,
    OP_FR_DBL = 3'd6,
    OP_TO_DBL = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MK_NORM = 2'd0,
    MK_ZERO = 2'd1,
    MK_INF  = 2'd2
  } mul_kind_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } stage_ctl_t;

  localparam int unsigned EXP_BIAS   = 16383;
  localparam int unsigned EXP_MAX    = 32767;
  localparam int unsigned ADD_CUTOFF = 110;
  localparam int unsigned SUB_CUTOFF = 112;
  localparam int unsigned PIPE_DEPTH = 5;

  localparam logic [63:0] REBIAS     = 64'h3C00000000000000;
  localparam logic [63:0] HALF_ULP_D = 64'h0800000000000000;

endpackage

FILE: sv/quad_float_arith_unit.sv
// ----------------------------------------------------------------------------
// quad_float_arith_unit: pipelined binary128 arithmetic, truncating
// Add, sub, mul, neg, compare, and double/quad conversion in one pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with in_operation and the operands.
//   busy is always low: a request is taken at every edge where start is high,
//   so one request per cycle is sustained.
//   Each request returns exactly one result:
//   out_valid is high for one cycle with out_result_hi, out_result_lo and
//   out_flag. Results leave in request order.
//   The pipeline has one input register, five stages in each of the add
//   and multiply datapaths (the 113x113 mantissa product is
//   built from 32x32 partial products and three adder levels), and one
//   output register.
//   The receiver cannot stall; results are never held back or repeated.
//   Reset (rst_n low, synchronous) drops all requests in flight and clears
//   out_valid and out_flag. Other payload registers are not reset.
// ----------------------------------------------------------------------------
module quad_float_arith_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_a_hi,
  input  logic [63:0] in_a_lo,
  input  logic [63:0] in_b_hi,
  input  logic [63:0] in_b_lo,
  output logic        out_valid,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  output logic        out_flag
);
  import qfau_pkg::*;

  // Never hold off a request: every stage advances each cycle.
  assign busy = 1'b0;

  // ---- input register --------------------------------------------------
  stage_ctl_t s0_ctl_r;
  quad_t      s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r.valid <= 1'b0;
    end else begin
      s0_ctl_r.valid <= start;
    end
    s0_ctl_r.op <= op_t'(in_operation);
    s0_a_r      <= {in_a_hi, in_a_lo};
    s0_b_r      <= {in_b_hi, in_b_lo};
  end

  // ---- arithmetic datapaths ---------------------------------------------
  quad_t add_b, add_res, mul_res;

  // sub adds the negated b
  assign add_b = {s0_b_r[127] ^ (s0_ctl_r.op == OP_SUB), s0_b_r[126:0]};

  qfau_add u_add (
    .clk   (clk),
    .a_i   (s0_a_r),
    .b_i   (add_b),
    .sum_o (add_res)
  );

  qfau_mul u_mul (
    .clk    (clk),
    .a_i    (s0_a_r),
    .b_i    (s0_b_r),
    .prod_o (mul_res)
  );

  // ---- combinational ops: neg, compares, conversions -------------------
  logic [63:0] a_hi, a_lo, dbl_sum, dbl_res;
  logic        eq, gt_mag, misc_flag_nxt;
  quad_t       misc_res_nxt;

  assign a_hi    = s0_a_r[127:64];
  assign a_lo    = s0_a_r[63:0];
  assign eq      = (s0_a_r == s0_b_r);
  assign gt_mag  = (s0_a_r > s0_b_r);
  assign dbl_sum = a_lo + HALF_ULP_D;

  always_comb begin
    // quad to double: keep the exponent only when it fits the double range
    if ((a_hi[61:58] == 4'h0) || (a_hi[61:58] == 4'hF)) begin
      dbl_res = {a_hi[63:62], a_hi[57:0], dbl_sum[63:60]};
    end else if (a_hi[62]) begin
      dbl_res = {a_hi[63], 11'h7FF, 52'd0};
    end else begin
      dbl_res = '0;
    end
  end

  always_comb begin
    misc_res_nxt  = '0;
    misc_flag_nxt = 1'b0;
    case (s0_ctl_r.op)
      OP_NEG: misc_res_nxt = {~s0_a_r[127], s0_a_r[126:0]};
      OP_GT: begin
        if (s0_a_r[127] != s0_b_r[127]) misc_flag_nxt = ~s0_a_r[127];
        else if (eq) misc_flag_nxt = 1'b0;
        else misc_flag_nxt = gt_mag ^ s0_a_r[127];
      end
      OP_EQ: misc_flag_nxt = eq;
      OP_FR_DBL: begin
        // zero double exponent flushes to +0
        if (a_hi[62:52] != '0) begin
          misc_res_nxt = {{5'd0, a_hi[62:4]} + REBIAS + {a_hi[63], 63'd0},
                          a_hi[3:0], 60'd0};
        end
      end
      OP_TO_DBL: misc_res_nxt = {dbl_res, 64'd0};
      default: misc_res_nxt = '0;
    endcase
  end

  // ---- control and side-result shift line, in step with the datapaths --
  stage_ctl_t ctl_r  [PIPE_DEPTH];
  quad_t      misc_r [PIPE_DEPTH];
  logic       flag_r [PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE_DEPTH; k++) ctl_r[k].valid <= 1'b0;
    end else begin
      ctl_r[0].valid <= s0_ctl_r.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) ctl_r[k].valid <= ctl_r[k-1].valid;
    end
    ctl_r[0].op <= s0_ctl_r.op;
    misc_r[0]   <= misc_res_nxt;
    flag_r[0]   <= misc_flag_nxt;
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      ctl_r[k].op <= ctl_r[k-1].op;
      misc_r[k]   <= misc_r[k-1];
      flag_r[k]   <= flag_r[k-1];
    end
  end

  // ---- output register: select the datapath by operation ---------------
  stage_ctl_t last_ctl;
  quad_t      out_res_nxt;
  logic       out_valid_r, out_flag_r;
  op_t        out_op_r;
  quad_t      out_res_r;

  assign last_ctl = ctl_r[PIPE_DEPTH-1];

  always_comb begin
    case (last_ctl.op)
      OP_ADD, OP_SUB: out_res_nxt = add_res;
      OP_MUL:         out_res_nxt = mul_res;
      default:        out_res_nxt = misc_r[PIPE_DEPTH-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_flag_r  <= 1'b0;
    end else begin
      out_valid_r <= last_ctl.valid;
      out_flag_r  <= last_ctl.valid & flag_r[PIPE_DEPTH-1];
    end
    out_op_r  <= last_ctl.op;
    out_res_r <= out_res_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_flag      = out_flag_r;
  assign out_result_hi = out_res_r[127:64];
  assign out_result_lo = out_res_r[63:0];

  // ---- assertions -------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##7 out_valid)
    else $error("request did not return a result after seven cycles");

  a_flag_ops: assert property (@(posedge clk) disable iff (!rst_n)
    out_flag |-> (out_valid && (out_op_r == OP_GT || out_op_r == OP_EQ)))
    else $error("flag raised for a non-compare operation");

  a_lo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_op_r == OP_GT || out_op_r == OP_EQ || out_op_r == OP_TO_DBL))
      |-> (out_result_lo == 64'd0))
    else $error("low result word not zero for compare or to-double");

  a_cmp_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_op_r == OP_GT || out_op_r == OP_EQ)) |-> (out_result_hi == 64'd0))
    else $error("high result word not zero for compare");

endmodule

FILE: sv/qfau_add.sv
// ----------------------------------------------------------------------------
// qfau_add: five-stage add/subtract pipeline
// Order operands, align, add or subtract, count leading zeros, normalize.
// ----------------------------------------------------------------------------
module qfau_add (
  input  logic           clk,
  input  qfau_pkg::quad_t a_i,
  input  qfau_pkg::quad_t b_i,
  output qfau_pkg::quad_t sum_o
);
  import qfau_pkg::*;

  // stage 1: order by magnitude
  logic  sa, sb, swap;
  qexp_t ea, eb;
  mant_t ma, mb;
  logic  s1_sl_r, s1_sub_r;
  qexp_t s1_el_r, s1_d_r;
  mant_t s1_ml_r, s1_mt_r;

  assign sa   = a_i[127];
  assign sb   = b_i[127];
  assign ea   = a_i[126:112];
  assign eb   = b_i[126:112];
  assign ma   = {1'b1, a_i[111:0]};
  assign mb   = {1'b1, b_i[111:0]};
  assign swap = (ea < eb) || ((ea == eb) && (mb > ma));

  always_ff @(posedge clk) begin
    s1_sub_r <= sa ^ sb;
    if (swap) begin
      s1_sl_r <= sb;
      s1_el_r <= eb;
      s1_d_r  <= eb - ea;
      s1_ml_r <= mb;
      s1_mt_r <= ma;
    end else begin
      s1_sl_r <= sa;
      s1_el_r <= ea;
      s1_d_r  <= ea - eb;
      s1_ml_r <= ma;
      s1_mt_r <= mb;
    end
  end

  // stage 2: align the trailing mantissa
  logic  s2_sl_r, s2_sub_r, s2_far_r;
  qexp_t s2_el_r;
  mant_t s2_ml_r, s2_mt_r;

  always_ff @(posedge clk) begin
    s2_sl_r  <= s1_sl_r;
    s2_sub_r <= s1_sub_r;
    s2_el_r  <= s1_el_r;
    s2_far_r <= s1_sub_r ? (s1_d_r >= 15'(SUB_CUTOFF)) : (s1_d_r >= 15'(ADD_CUTOFF));
    s2_ml_r  <= s1_ml_r;
    s2_mt_r  <= s1_mt_r >> s1_d_r;
  end

  // stage 3: add or subtract
  logic         s3_sl_r, s3_sub_r, s3_far_r;
  qexp_t        s3_el_r;
  mant_t        s3_ml_r;
  logic [113:0] s3_r_r;

  always_ff @(posedge clk) begin
    s3_sl_r  <= s2_sl_r;
    s3_sub_r <= s2_sub_r;
    s3_far_r <= s2_far_r;
    s3_el_r  <= s2_el_r;
    s3_ml_r  <= s2_ml_r;
    s3_r_r   <= s2_sub_r ? ({1'b0, s2_ml_r} - {1'b0, s2_mt_r})
                         : ({1'b0, s2_ml_r} + {1'b0, s2_mt_r});
  end

  // stage 4: leading zero count of the difference
  logic [6:0]   pos;
  logic         s4_sl_r, s4_sub_r, s4_far_r, s4_zero_r;
  qexp_t        s4_el_r;
  mant_t        s4_ml_r;
  logic [113:0] s4_r_r;
  logic [6:0]   s4_lzc_r;

  always_comb begin
    pos = '0;
    for (int i = 0; i < 113; i++) begin
      if (s3_r_r[i]) pos = 7'(i);
    end
  end

  always_ff @(posedge clk) begin
    s4_sl_r   <= s3_sl_r;
    s4_sub_r  <= s3_sub_r;
    s4_far_r  <= s3_far_r;
    s4_el_r   <= s3_el_r;
    s4_ml_r   <= s3_ml_r;
    s4_r_r    <= s3_r_r;
    s4_zero_r <= (s3_r_r == '0);
    s4_lzc_r  <= 7'd112 - pos;
  end

  // stage 5: normalize and pack
  logic [15:0]  e_up;
  logic [113:0] r_rs, r_ls;
  qexp_t        e_dn;
  quad_t        res;
  quad_t        s5_res_r;

  always_comb begin
    e_up = {1'b0, s4_el_r} + 16'd1;
    r_rs = s4_r_r >> 1;
    r_ls = s4_r_r << s4_lzc_r;
    e_dn = s4_el_r - {8'd0, s4_lzc_r};
    if (s4_far_r) begin
      res = {s4_sl_r, s4_el_r, s4_ml_r[111:0]};
    end else if (!s4_sub_r) begin
      if (s4_r_r[113]) begin
        if (e_up > 16'(EXP_MAX)) res = {s4_sl_r, 15'h7FFF, 112'd0};
        else res = {s4_sl_r, e_up[14:0], r_rs[111:0]};
      end else begin
        res = {s4_sl_r, s4_el_r, s4_r_r[111:0]};
      end
    end else if (s4_zero_r || ({8'd0, s4_lzc_r} > s4_el_r)) begin
      res = '0;
    end else begin
      res = {s4_sl_r, e_dn, r_ls[111:0]};
    end
  end

  always_ff @(posedge clk) begin
    s5_res_r <= res;
  end

  assign sum_o = s5_res_r;

endmodule

FILE: sv/qfau_mul.sv
// ----------------------------------------------------------------------------
// qfau_mul: five-stage multiply pipeline
// 32x32 partial products, three registered adder levels, normalize and pack.
// ----------------------------------------------------------------------------
module qfau_mul (
  input  logic           clk,
  input  qfau_pkg::quad_t a_i,
  input  qfau_pkg::quad_t b_i,
  output qfau_pkg::quad_t prod_o
);
  import qfau_pkg::*;

  // stage 1: exponent classify and partial products
  logic [15:0]  esum;
  logic [127:0] ma, mb;
  mul_kind_t    kind;
  logic [15:0]  e_diff;
  logic [63:0]  s1_pp_r [4][4];
  logic         s1_sc_r;
  mul_kind_t    s1_kind_r;
  qexp_t        s1_e_r;

  assign esum   = {1'b0, a_i[126:112]} + {1'b0, b_i[126:112]};
  assign e_diff = esum - 16'(EXP_BIAS);
  assign ma     = {15'd0, 1'b1, a_i[111:0]};
  assign mb     = {15'd0, 1'b1, b_i[111:0]};

  always_comb begin
    if ((a_i[126:112] == '0) || (b_i[126:112] == '0) || (esum <= 16'(EXP_BIAS))) begin
      kind = MK_ZERO;
    end else if (esum >= 16'(EXP_BIAS + EXP_MAX)) begin
      kind = MK_INF;
    end else begin
      kind = MK_NORM;
    end
  end

  always_ff @(posedge clk) begin
    s1_sc_r   <= a_i[127] ^ b_i[127];
    s1_kind_r <= kind;
    s1_e_r    <= e_diff[14:0];
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s1_pp_r[i][j] <= ma[32*i +: 32] * mb[32*j +: 32];
      end
    end
  end

  // stage 2: one row per limb of a
  logic [159:0] s2_row_r [4];
  logic         s2_sc_r;
  mul_kind_t    s2_kind_r;
  qexp_t        s2_e_r;

  always_ff @(posedge clk) begin
    s2_sc_r   <= s1_sc_r;
    s2_kind_r <= s1_kind_r;
    s2_e_r    <= s1_e_r;
    for (int i = 0; i < 4; i++) begin
      s2_row_r[i] <= {96'd0, s1_pp_r[i][0]} + {64'd0, s1_pp_r[i][1], 32'd0}
                   + {32'd0, s1_pp_r[i][2], 64'd0} + {s1_pp_r[i][3], 96'd0};
    end
  end

  // stage 3: pairwise row sums
  logic [192:0] s3_lo_r, s3_hi_r;
  logic         s3_sc_r;
  mul_kind_t    s3_kind_r;
  qexp_t        s3_e_r;

  always_ff @(posedge clk) begin
    s3_sc_r   <= s2_sc_r;
    s3_kind_r <= s2_kind_r;
    s3_e_r    <= s2_e_r;
    s3_lo_r   <= {33'd0, s2_row_r[0]} + {1'd0, s2_row_r[1], 32'd0};
    s3_hi_r   <= {33'd0, s2_row_r[2]} + {1'd0, s2_row_r[3], 32'd0};
  end

  // stage 4: full product
  logic [256:0] s4_p_r;
  logic         s4_sc_r;
  mul_kind_t    s4_kind_r;
  qexp_t        s4_e_r;

  always_ff @(posedge clk) begin
    s4_sc_r   <= s3_sc_r;
    s4_kind_r <= s3_kind_r;
    s4_e_r    <= s3_e_r;
    s4_p_r    <= {64'd0, s3_lo_r} + {s3_hi_r, 64'd0};
  end

  // stage 5: take the high part, renormalize right once, pack
  // Product bits below 128 are dropped; at least the low 15 fraction bits stay zero (16 without the right shift).
  logic [113:0] r;
  quad_t        res;
  quad_t        s5_res_r;

  assign r = {s4_p_r[225:128], 16'd0};

  always_comb begin
    case (s4_kind_r)
      MK_ZERO: res = '0;
      MK_INF:  res = {s4_sc_r, 15'h7FFF, 112'd0};
      default: begin
        if (r[113]) res = {s4_sc_r, s4_e_r + 15'd1, r[112:1]};
        else res = {s4_sc_r, s4_e_r, r[111:0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s5_res_r <= res;
  end

  assign prod_o = s5_res_r;

endmodule
